/* hdl/swa_pkg.sv */
// Shared types, widths and helpers for the sliding window statistics block.
// Holds the partial aggregate record and the fixed field widths; no dependencies.
`default_nettype none

package swa_pkg;

  localparam int unsigned WINDOW_DEPTH_DEF = 256;
  localparam int unsigned SAMPLE_WIDTH_DEF = 32;

  localparam int unsigned VAL_W     = 32;
  localparam int unsigned CNT_W     = 9;
  localparam int unsigned M2_W      = 64;
  localparam int unsigned LEN_W     = 9;
  localparam int unsigned LEN_RESET = 256;

  // Widths inside the merge datapath.
  localparam int unsigned N_W    = CNT_W + 1;
  localparam int unsigned NN_W   = 2 * CNT_W;
  localparam int unsigned SUM_W  = VAL_W + N_W;
  localparam int unsigned DIFF_W = VAL_W;
  localparam int unsigned P1_W   = DIFF_W + NN_W;
  localparam int unsigned P2_W   = P1_W + DIFF_W;
  localparam int unsigned STEP_W = $clog2(P2_W + 1);
  localparam int unsigned CYC_W  = $clog2(DIFF_W + 1);

  typedef struct packed {
    logic signed [VAL_W-1:0] mn;
    logic signed [VAL_W-1:0] mx;
    logic [CNT_W-1:0]        cnt;
    logic signed [VAL_W-1:0] mean;
    logic [M2_W-1:0]         m2;
  } agg_t;

  localparam agg_t EMPTY_AGG = '{
    mn:   32'sh7FFF_FFFF,
    mx:   32'sh8000_0000,
    cnt:  '0,
    mean: '0,
    m2:   '0
  };

  function automatic logic [M2_W-1:0] sat_add(input logic [M2_W-1:0] a,
                                               input logic [M2_W-1:0] b);
    logic [M2_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[M2_W] ? '1 : s[M2_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* hdl/swa_if.sv */
// Valid/ready channel interfaces for the input items and the result items.
// Depends on swa_pkg for the field widths.
`default_nettype none

interface swa_in_if import swa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             op;
  logic [VAL_W-1:0] sample;
  logic             sample_valid;

  modport source (output valid, output op, output sample, output sample_valid, input ready);
  modport sink (input valid, input op, input sample, input sample_valid, output ready);
endinterface

interface swa_out_if import swa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] window_count;
  logic [VAL_W-1:0] window_min;
  logic [VAL_W-1:0] window_max;
  logic [VAL_W-1:0] window_mean;
  logic [M2_W-1:0]  window_m2;
  logic             rejected;

  modport source (output valid, output window_count, output window_min, output window_max,
                  output window_mean, output window_m2, output rejected, input ready);
  modport sink (input valid, input window_count, input window_min, input window_max,
                input window_mean, input window_m2, input rejected, output ready);
endinterface

`default_nettype wire

/* hdl/swa_ring.sv */
// Ring store of partial aggregates: one write port and one registered read port.
// Depends on swa_pkg for the aggregate record.
`default_nettype none

module swa_ring import swa_pkg::*; #(
  parameter int unsigned DEPTH = WINDOW_DEPTH_DEF,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  agg_t              wr_data_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output agg_t              rd_data_o
);

  agg_t mem [DEPTH];
  agg_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

/* hdl/swa_div.sv */
// Restoring divider that produces one quotient bit per cycle.
// Depends on swa_pkg for the datapath widths.
`default_nettype none

module swa_div import swa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [P2_W-1:0]   dividend_i,
  input  logic [N_W-1:0]    divisor_i,
  input  logic [STEP_W-1:0] steps_i,
  output logic              done_o,
  output logic [P2_W-1:0]   quot_o,
  output logic [N_W-1:0]    rem_o
);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] cnt_q;
  logic [P2_W-1:0]   dvd_q;
  logic [P2_W-1:0]   quo_q;
  logic [N_W-1:0]    rem_q;
  logic [N_W-1:0]    dsr_q;

  logic [N_W:0]   trial;
  logic [N_W:0]   diff;
  logic           ge;
  logic [N_W-1:0] rem_nx;

  always_comb begin
    trial  = {rem_q, dvd_q[P2_W-1]};
    diff   = trial - {1'b0, dsr_q};
    ge     = (trial >= {1'b0, dsr_q});
    rem_nx = ge ? diff[N_W-1:0] : trial[N_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == STEP_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= steps_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - STEP_W'(1);
        if (cnt_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      quo_q <= '0;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[P2_W-2:0], 1'b0};
      quo_q <= {quo_q[P2_W-2:0], ge};
      rem_q <= rem_nx;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

/* hdl/swa_merge.sv */
// Bit-serial merge of two partial aggregates (count, min, max, mean, M2).
// Depends on swa_pkg and the serial divider swa_div.
`default_nettype none

module swa_merge import swa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  agg_t a_i,
  input  agg_t b_i,
  output logic done_o,
  output agg_t res_o
);

  localparam logic [2:0] M_IDLE = 3'd0;
  localparam logic [2:0] M_PROD = 3'd1;
  localparam logic [2:0] M_MUL1 = 3'd2;
  localparam logic [2:0] M_MUL2 = 3'd3;
  localparam logic [2:0] M_DIV1 = 3'd4;
  localparam logic [2:0] M_DIV2 = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [CYC_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;

  logic [CNT_W-1:0]        mla_q, mlb_q;
  logic [SUM_W-1:0]        mca_q, mcb_q, s_q;
  logic [NN_W-1:0]         nsh_q, nanb_q, mlr1_q;
  logic [DIFF_W-1:0]       d_q, mlr2_q;
  logic [N_W-1:0]          n_q;
  logic [P1_W-1:0]         mc1_q, p1_q;
  logic [P2_W-1:0]         mc2_q, p2_q;
  logic [M2_W-1:0]         m2ab_q, term_q;
  logic signed [VAL_W-1:0] mn_q, mx_q;
  agg_t                    res_q;

  logic [SUM_W-1:0]  s_nx;
  logic [NN_W-1:0]   nanb_nx;
  logic [P1_W-1:0]   p1_nx;
  logic [P2_W-1:0]   p2_nx;
  logic [N_W-1:0]    n_st;
  logic [DIFF_W:0]   diff_st;
  logic [DIFF_W-1:0] d_st;
  logic [SUM_W-1:0]  u_abs;
  logic [SUM_W-1:0]  mean_dvd;
  logic              round_up;
  logic [P2_W:0]     q_rnd;
  logic [M2_W-1:0]   term_nx;
  logic [VAL_W-1:0]  mean_fin;

  logic              div_start;
  logic [P2_W-1:0]   div_dividend;
  logic [STEP_W-1:0] div_steps;
  logic              div_done;
  logic [P2_W-1:0]   div_quo;
  logic [N_W-1:0]    div_rem;

  swa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (n_q),
    .steps_i    (div_steps),
    .done_o     (div_done),
    .quot_o     (div_quo),
    .rem_o      (div_rem)
  );

  always_comb begin
    s_nx    = s_q + (mla_q[0] ? mca_q : '0) + (mlb_q[0] ? mcb_q : '0);
    nanb_nx = nanb_q + (mlb_q[0] ? nsh_q : '0);
    p1_nx   = p1_q + (mlr1_q[0] ? mc1_q : '0);
    p2_nx   = p2_q + (mlr2_q[0] ? mc2_q : '0);

    n_st    = N_W'(a_i.cnt) + N_W'(b_i.cnt);
    diff_st = (DIFF_W+1)'($signed(b_i.mean)) - (DIFF_W+1)'($signed(a_i.mean));
    d_st    = diff_st[DIFF_W] ? DIFF_W'(-diff_st) : diff_st[DIFF_W-1:0];

    // The weighted sum is rounded half away from zero by working on its magnitude.
    u_abs    = s_q[SUM_W-1] ? -s_q : s_q;
    mean_dvd = u_abs + SUM_W'(n_q >> 1);

    round_up = ({div_rem, 1'b0} >= {1'b0, n_q});
    q_rnd    = {1'b0, div_quo} + (P2_W+1)'(round_up);
    term_nx  = (|q_rnd[P2_W:M2_W]) ? '1 : q_rnd[M2_W-1:0];

    mean_fin = s_q[SUM_W-1] ? -div_quo[VAL_W-1:0] : div_quo[VAL_W-1:0];
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    done_d       = 1'b0;
    div_start    = 1'b0;
    div_dividend = '0;
    div_steps    = '0;
    case (state_q)
      M_IDLE: begin
        if (start_i) begin
          // An empty side leaves the other aggregate exactly as it is.
          if (a_i.cnt == '0 || b_i.cnt == '0) begin
            done_d = 1'b1;
          end else begin
            state_d = M_PROD;
            cnt_d   = CYC_W'(CNT_W);
          end
        end
      end
      M_PROD: begin
        cnt_d = cnt_q - CYC_W'(1);
        if (cnt_q == CYC_W'(1)) begin
          state_d = M_MUL1;
          cnt_d   = CYC_W'(NN_W);
        end
      end
      M_MUL1: begin
        cnt_d = cnt_q - CYC_W'(1);
        if (cnt_q == CYC_W'(1)) begin
          state_d = M_MUL2;
          cnt_d   = CYC_W'(DIFF_W);
        end
      end
      M_MUL2: begin
        cnt_d = cnt_q - CYC_W'(1);
        if (cnt_q == CYC_W'(1)) begin
          state_d      = M_DIV1;
          div_start    = 1'b1;
          div_dividend = p2_nx;
          div_steps    = STEP_W'(P2_W);
        end
      end
      M_DIV1: begin
        if (div_done) begin
          state_d      = M_DIV2;
          div_start    = 1'b1;
          div_dividend = {mean_dvd, {(P2_W-SUM_W){1'b0}}};
          div_steps    = STEP_W'(SUM_W);
        end
      end
      M_DIV2: begin
        if (div_done) begin
          state_d = M_IDLE;
          done_d  = 1'b1;
        end
      end
      default: begin
        state_d = M_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      M_IDLE: begin
        if (start_i) begin
          mla_q  <= a_i.cnt;
          mlb_q  <= b_i.cnt;
          mca_q  <= SUM_W'($signed(a_i.mean));
          mcb_q  <= SUM_W'($signed(b_i.mean));
          nsh_q  <= NN_W'(a_i.cnt);
          s_q    <= '0;
          nanb_q <= '0;
          d_q    <= d_st;
          n_q    <= n_st;
          m2ab_q <= sat_add(a_i.m2, b_i.m2);
          mn_q   <= (a_i.mn < b_i.mn) ? a_i.mn : b_i.mn;
          mx_q   <= (a_i.mx > b_i.mx) ? a_i.mx : b_i.mx;
          if (n_st == '0) begin
            res_q <= EMPTY_AGG;
          end else if (b_i.cnt == '0) begin
            res_q <= a_i;
          end else begin
            res_q <= b_i;
          end
        end
      end
      M_PROD: begin
        s_q    <= s_nx;
        nanb_q <= nanb_nx;
        mca_q  <= {mca_q[SUM_W-2:0], 1'b0};
        mcb_q  <= {mcb_q[SUM_W-2:0], 1'b0};
        nsh_q  <= {nsh_q[NN_W-2:0], 1'b0};
        mla_q  <= mla_q >> 1;
        mlb_q  <= mlb_q >> 1;
        if (cnt_q == CYC_W'(1)) begin
          p1_q   <= '0;
          mc1_q  <= P1_W'(d_q);
          mlr1_q <= nanb_nx;
        end
      end
      M_MUL1: begin
        p1_q   <= p1_nx;
        mc1_q  <= {mc1_q[P1_W-2:0], 1'b0};
        mlr1_q <= mlr1_q >> 1;
        if (cnt_q == CYC_W'(1)) begin
          p2_q   <= '0;
          mc2_q  <= P2_W'(p1_nx);
          mlr2_q <= d_q;
        end
      end
      M_MUL2: begin
        p2_q   <= p2_nx;
        mc2_q  <= {mc2_q[P2_W-2:0], 1'b0};
        mlr2_q <= mlr2_q >> 1;
      end
      M_DIV1: begin
        if (div_done) begin
          term_q <= term_nx;
        end
      end
      M_DIV2: begin
        if (div_done) begin
          res_q.mn   <= mn_q;
          res_q.mx   <= mx_q;
          res_q.cnt  <= n_q[CNT_W-1:0];
          res_q.mean <= mean_fin;
          res_q.m2   <= sat_add(m2ab_q, term_q);
        end
      end
      default: begin
      end
    endcase
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

/* hdl/sliding_window_statistics.sv */
// Top level of the sliding window statistics block: sequencer, ring store and merge unit.
// Depends on swa_pkg, swa_if, swa_ring and swa_merge.
//
// Each beat either inserts a sample at the back of the window or evicts the oldest one, and
// every accepted beat yields exactly one result beat with count, min, max, mean and M2 of the
// valid samples left in the window. Partial aggregates live in a ring store with one read and
// one write port and are combined by a single bit-serial merge unit. A merge with an empty side
// skips the serial steps; a full merge forms the weighted sums, runs the two serial
// multiplications and then the two divisions on the one-bit-per-cycle divider. An item needs up
// to four merges plus sequencing states; an evict on an empty window needs no merge. A new input
// beat is taken while a finished result still waits at the output register. Writing the window
// length empties the window; it takes effect at once and needs no clearing pass.
`default_nettype none

module sliding_window_statistics import swa_pkg::*; #(
  parameter int unsigned WINDOW_DEPTH = WINDOW_DEPTH_DEF,
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [LEN_W-1:0] cfg_wdata_i,
  swa_in_if.sink           in_i,
  swa_out_if.source        out_o
);

  localparam int unsigned ADDR_W = $clog2(WINDOW_DEPTH);
  localparam int unsigned POS_W  = (ADDR_W + 1 > N_W) ? ADDR_W + 1 : N_W;

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_INS_MRG  = 4'd1;
  localparam logic [3:0] ST_FLIP     = 4'd2;
  localparam logic [3:0] ST_ADV      = 4'd3;
  localparam logic [3:0] ST_DV_CAP   = 4'd4;
  localparam logic [3:0] ST_ACC_CAP  = 4'd5;
  localparam logic [3:0] ST_ACC_MRG  = 4'd6;
  localparam logic [3:0] ST_LEFT     = 4'd7;
  localparam logic [3:0] ST_LEFT_CAP = 4'd8;
  localparam logic [3:0] ST_LEFT_MRG = 4'd9;
  localparam logic [3:0] ST_MID_CAP  = 4'd10;
  localparam logic [3:0] ST_RES      = 4'd11;
  localparam logic [3:0] ST_RES_CAP  = 4'd12;
  localparam logic [3:0] ST_RES_MRG  = 4'd13;
  localparam logic [3:0] ST_FIN      = 4'd14;

  function automatic logic [POS_W-1:0] eff_of(input logic [LEN_W-1:0] v);
    logic [POS_W-1:0] w;
    w = POS_W'(v);
    if (w == '0) begin
      return POS_W'(1);
    end else if (w > POS_W'(WINDOW_DEPTH)) begin
      return POS_W'(WINDOW_DEPTH);
    end
    return w;
  endfunction

  // Positions run over twice the length so that a full ring differs from an empty one.
  function automatic logic [POS_W-1:0] pos_next(input logic [POS_W-1:0] p,
                                                input logic [POS_W-1:0] len);
    logic [POS_W:0] inc;
    logic [POS_W:0] twice;
    inc   = {1'b0, p} + (POS_W+1)'(1);
    twice = {len, 1'b0};
    return (inc >= twice) ? '0 : inc[POS_W-1:0];
  endfunction

  function automatic logic [POS_W-1:0] pos_prev(input logic [POS_W-1:0] p,
                                                input logic [POS_W-1:0] len);
    logic [POS_W:0] last;
    last = {len, 1'b0} - (POS_W+1)'(1);
    return (p == '0) ? last[POS_W-1:0] : p - POS_W'(1);
  endfunction

  function automatic logic [ADDR_W-1:0] slot_of(input logic [POS_W-1:0] p,
                                                input logic [POS_W-1:0] len);
    logic [POS_W-1:0] s;
    s = (p >= len) ? p - len : p;
    return s[ADDR_W-1:0];
  endfunction

  logic [3:0]       state_q;
  logic [POS_W-1:0] eff_q;
  logic [POS_W-1:0] head_q, tail_q, left_q, right_q, accum_q, back_q;
  logic [CNT_W-1:0] occ_q;
  agg_t             back_sum_q, mid_q;
  logic             flag_q;
  logic             rej_q;
  logic             out_valid_q;
  agg_t             op_b_q;
  agg_t             res_q;
  agg_t             out_res_q;
  logic             out_rej_q;

  logic                     in_fire;
  logic                     full;
  logic                     out_free;
  logic signed [SAMPLE_WIDTH-1:0] smp_narrow;
  logic signed [VAL_W-1:0]  smp_val;
  agg_t                     lifted;
  logic [POS_W-1:0]         accum_prev, accum_next;

  logic                     mrg_start;
  agg_t                     mrg_a, mrg_b, mrg_res;
  logic                     mrg_done;

  logic [POS_W-1:0]         rd_pos, wr_pos;
  logic                     wr_en;
  agg_t                     wr_data, rd_data;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign full       = (POS_W'(occ_q) >= eff_q);
  assign out_free   = !out_valid_q || out_o.ready;
  assign accum_prev = pos_prev(accum_q, eff_q);
  assign accum_next = pos_next(accum_q, eff_q);

  always_comb begin
    smp_narrow = in_i.sample[SAMPLE_WIDTH-1:0];
    smp_val    = VAL_W'(smp_narrow);
    if (in_i.sample_valid) begin
      lifted.mn   = smp_val;
      lifted.mx   = smp_val;
      lifted.cnt  = CNT_W'(1);
      lifted.mean = smp_val;
      lifted.m2   = '0;
    end else begin
      lifted = EMPTY_AGG;
    end
  end

  swa_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mrg_start),
    .a_i     (mrg_a),
    .b_i     (mrg_b),
    .done_o  (mrg_done),
    .res_o   (mrg_res)
  );

  swa_ring #(.DEPTH(WINDOW_DEPTH)) u_ring (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (slot_of(wr_pos, eff_q)),
    .wr_data_i (wr_data),
    .rd_addr_i (slot_of(rd_pos, eff_q)),
    .rd_data_o (rd_data)
  );

  always_comb begin
    mrg_start = 1'b0;
    mrg_a     = back_sum_q;
    mrg_b     = lifted;
    rd_pos    = head_q;
    wr_en     = 1'b0;
    wr_pos    = tail_q;
    wr_data   = op_b_q;
    case (state_q)
      ST_IDLE: begin
        mrg_start = in_fire && !in_i.op && !full;
      end
      ST_INS_MRG: begin
        wr_en = mrg_done;
      end
      ST_ADV: begin
        rd_pos = accum_q;
      end
      ST_DV_CAP: begin
        rd_pos = accum_prev;
      end
      ST_ACC_CAP: begin
        mrg_start = 1'b1;
        mrg_a     = rd_data;
        mrg_b     = op_b_q;
      end
      ST_ACC_MRG: begin
        wr_en   = mrg_done;
        wr_pos  = accum_q;
        wr_data = mrg_res;
      end
      ST_LEFT: begin
        rd_pos = (left_q != right_q) ? left_q : accum_next;
      end
      ST_LEFT_CAP: begin
        mrg_start = 1'b1;
        mrg_a     = rd_data;
        mrg_b     = mid_q;
      end
      ST_LEFT_MRG: begin
        wr_en   = mrg_done;
        wr_pos  = left_q;
        wr_data = mrg_res;
      end
      ST_RES: begin
        rd_pos = head_q;
      end
      ST_RES_CAP: begin
        mrg_start = 1'b1;
        mrg_a     = flag_q ? EMPTY_AGG : rd_data;
        mrg_b     = back_sum_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      eff_q       <= eff_of(LEN_W'(LEN_RESET));
      head_q      <= '0;
      tail_q      <= '0;
      left_q      <= '0;
      right_q     <= '0;
      accum_q     <= '0;
      back_q      <= '0;
      occ_q       <= '0;
      back_sum_q  <= EMPTY_AGG;
      mid_q       <= EMPTY_AGG;
      flag_q      <= 1'b0;
      rej_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!cfg_we_i && state_q == ST_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        eff_q      <= eff_of(cfg_wdata_i);
        head_q     <= '0;
        tail_q     <= '0;
        left_q     <= '0;
        right_q    <= '0;
        accum_q    <= '0;
        back_q     <= '0;
        occ_q      <= '0;
        back_sum_q <= EMPTY_AGG;
        mid_q      <= EMPTY_AGG;
      end else begin
        case (state_q)
          ST_IDLE: begin
            if (in_fire) begin
              rej_q <= !in_i.op && full;
              if (!in_i.op) begin
                if (full) begin
                  state_q <= ST_RES;
                end else begin
                  state_q <= ST_INS_MRG;
                end
              end else if (occ_q != '0) begin
                head_q  <= pos_next(head_q, eff_q);
                occ_q   <= occ_q - CNT_W'(1);
                state_q <= ST_FLIP;
              end else begin
                state_q <= ST_RES;
              end
            end
          end
          ST_INS_MRG: begin
            if (mrg_done) begin
              back_sum_q <= mrg_res;
              tail_q     <= pos_next(tail_q, eff_q);
              occ_q      <= occ_q + CNT_W'(1);
              state_q    <= ST_FLIP;
            end
          end
          ST_FLIP: begin
            // The front list is used up: the back list becomes the new middle.
            if (left_q == back_q) begin
              left_q     <= head_q;
              right_q    <= back_q;
              accum_q    <= tail_q;
              back_q     <= tail_q;
              mid_q      <= back_sum_q;
              back_sum_q <= EMPTY_AGG;
            end
            state_q <= ST_ADV;
          end
          ST_ADV: begin
            if (head_q != back_q) begin
              if (accum_q != right_q) begin
                flag_q  <= (accum_q == back_q);
                state_q <= ST_DV_CAP;
              end else begin
                state_q <= ST_LEFT;
              end
            end else begin
              back_sum_q <= EMPTY_AGG;
              mid_q      <= EMPTY_AGG;
              state_q    <= ST_RES;
            end
          end
          ST_DV_CAP: begin
            accum_q <= accum_prev;
            state_q <= ST_ACC_CAP;
          end
          ST_ACC_CAP: begin
            state_q <= ST_ACC_MRG;
          end
          ST_ACC_MRG: begin
            if (mrg_done) begin
              state_q <= ST_LEFT;
            end
          end
          ST_LEFT: begin
            if (left_q != right_q) begin
              state_q <= ST_LEFT_CAP;
            end else begin
              left_q  <= pos_next(left_q, eff_q);
              right_q <= pos_next(right_q, eff_q);
              accum_q <= accum_next;
              flag_q  <= (accum_next == back_q);
              state_q <= ST_MID_CAP;
            end
          end
          ST_LEFT_CAP: begin
            state_q <= ST_LEFT_MRG;
          end
          ST_LEFT_MRG: begin
            if (mrg_done) begin
              left_q  <= pos_next(left_q, eff_q);
              state_q <= ST_RES;
            end
          end
          ST_MID_CAP: begin
            mid_q   <= flag_q ? EMPTY_AGG : rd_data;
            state_q <= ST_RES;
          end
          ST_RES: begin
            if (occ_q == '0) begin
              state_q <= ST_FIN;
            end else begin
              flag_q  <= (head_q == back_q);
              state_q <= ST_RES_CAP;
            end
          end
          ST_RES_CAP: begin
            state_q <= ST_RES_MRG;
          end
          ST_RES_MRG: begin
            if (mrg_done) begin
              state_q <= ST_FIN;
            end
          end
          ST_FIN: begin
            if (out_free) begin
              state_q <= ST_IDLE;
            end
          end
          default: begin
            state_q <= ST_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          op_b_q <= lifted;
        end
      end
      ST_DV_CAP: begin
        op_b_q <= flag_q ? EMPTY_AGG : rd_data;
      end
      ST_RES: begin
        if (occ_q == '0) begin
          res_q <= EMPTY_AGG;
        end
      end
      ST_RES_MRG: begin
        if (mrg_done) begin
          res_q <= mrg_res;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_res_q <= res_q;
          out_rej_q <= rej_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.window_count = out_res_q.cnt;
  assign out_o.window_min   = out_res_q.mn;
  assign out_o.window_max   = out_res_q.mx;
  assign out_o.window_mean  = out_res_q.mean;
  assign out_o.window_m2    = out_res_q.m2;
  assign out_o.rejected     = out_rej_q;

endmodule

`default_nettype wire
